// ----- sv/rotation_matrix_to_quaternion_unit_assert.svh -----
// Assertion macros shared by the rotation-matrix-to-quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// Condition must hold on every clock outside reset.
`define RMQ_ASSERT_HOLDS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rmq invariant violated");

// Whenever ante holds, cons must hold in the same cycle.
`define RMQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmq implication violated");

`endif

// ----- sv/rmq_pkg.sv -----
// Types and constants for the rotation-matrix-to-quaternion pipeline.
package rmq_pkg;

	localparam int EL_W     = 16;              // matrix element and quaternion field width
	localparam int RAD_W    = 17;              // radicand, Q14, clamped nonnegative
	localparam int SQ_PAD   = 12;              // radicand is scaled by 4096 before the root
	localparam int NUM_W    = 1 + RAD_W + SQ_PAD;
	localparam int ROOT_W   = 15;              // floor(sqrt(R*4096)) < 2^15
	localparam int SQ_STEPS = ROOT_W;          // one root bit per stage
	localparam int D_W      = 17;              // sum or difference of two elements
	localparam int QUO_W    = 17;              // quotient bits below the overflow check
	localparam int LANES    = 3;

	localparam logic [ROOT_W-1:0] ROOT_MAX = 15'd23170;
	localparam logic signed [18:0] Q_ONE   = 19'sd16384;

	typedef logic signed [EL_W-1:0] el_t;

	typedef struct packed {
		el_t m00;
		el_t m01;
		el_t m02;
		el_t m10;
		el_t m11;
		el_t m12;
		el_t m20;
		el_t m21;
		el_t m22;
	} mat_t;

	typedef struct packed {
		el_t quat_w;
		el_t quat_x;
		el_t quat_y;
		el_t quat_z;
	} quat_t;

	// Component taken straight from the root.
	typedef enum logic [1:0] {
		PRIM_W,
		PRIM_X,
		PRIM_Y,
		PRIM_Z
	} prim_t;

	// Lane 0 is w unless w is primary; see route in rmq_div.
	typedef struct packed {
		prim_t                             prim;
		logic [LANES-1:0][D_W-1:0]         d;
	} side_t;

endpackage

// ----- sv/rmq_front.sv -----
// Branch select, radicand and off-diagonal sums/differences (stage 1).
module rmq_front
	import rmq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vld_in,
	input  mat_t               mat,
	output logic               vld_s1,
	output logic [RAD_W-1:0]   rad_s1,
	output side_t              side_s1
);

	logic signed [18:0] tr;
	logic signed [18:0] r;
	logic signed [18:0] a00, a11, a22;
	logic               sel1, sel2;
	side_t              side;

	always_comb begin
		a00 = 19'(mat.m00);
		a11 = 19'(mat.m11);
		a22 = 19'(mat.m22);
		tr  = a00 + a11 + a22;
		sel1 = a11 > a00;
		sel2 = sel1 ? (a22 > a11) : (a22 > a00);
		side.prim = PRIM_W;
		side.d    = '0;
		r         = tr + Q_ONE;
		if (tr > 19'sd0) begin
			side.prim = PRIM_W;
			side.d[0] = D_W'(mat.m12) - D_W'(mat.m21);
			side.d[1] = D_W'(mat.m20) - D_W'(mat.m02);
			side.d[2] = D_W'(mat.m01) - D_W'(mat.m10);
		end else if (sel2) begin
			side.prim = PRIM_Z;
			r         = a22 - (a00 + a11) + Q_ONE;
			side.d[0] = D_W'(mat.m01) - D_W'(mat.m10);
			side.d[1] = D_W'(mat.m20) + D_W'(mat.m02);
			side.d[2] = D_W'(mat.m21) + D_W'(mat.m12);
		end else if (sel1) begin
			side.prim = PRIM_Y;
			r         = a11 - (a22 + a00) + Q_ONE;
			side.d[0] = D_W'(mat.m20) - D_W'(mat.m02);
			side.d[1] = D_W'(mat.m12) + D_W'(mat.m21);
			side.d[2] = D_W'(mat.m10) + D_W'(mat.m01);
		end else begin
			side.prim = PRIM_X;
			r         = a00 - (a11 + a22) + Q_ONE;
			side.d[0] = D_W'(mat.m12) - D_W'(mat.m21);
			side.d[1] = D_W'(mat.m01) + D_W'(mat.m10);
			side.d[2] = D_W'(mat.m02) + D_W'(mat.m20);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s1  <= r[18] ? '0 : r[RAD_W-1:0];
			side_s1 <= side;
		end
	end

endmodule

// ----- sv/rmq_sqrt.sv -----
// Pipelined integer square root of R*4096, one result bit per stage.
`include "rotation_matrix_to_quaternion_unit_assert.svh"
module rmq_sqrt
	import rmq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vld_in,
	input  logic [RAD_W-1:0]   rad_in,
	input  side_t              side_in,
	output logic               vld_out,
	output logic [ROOT_W-1:0]  root_out,
	output side_t              side_out
);

	logic               sq_vld_s  [SQ_STEPS+1];
	logic [RAD_W-1:0]   sq_rad_s  [SQ_STEPS+1];
	logic [ROOT_W-1:0]  sq_root_s [SQ_STEPS+1];
	logic [ROOT_W+1:0]  sq_rem_s  [SQ_STEPS+1];
	side_t              sq_side_s [SQ_STEPS+1];

	assign sq_vld_s[0]  = vld_in;
	assign sq_rad_s[0]  = rad_in;
	assign sq_root_s[0] = '0;
	assign sq_rem_s[0]  = '0;
	assign sq_side_s[0] = side_in;

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
		localparam int HI = NUM_W - 1 - 2 * g;
		logic [NUM_W-1:0]  vx;
		logic [ROOT_W+3:0] remx;
		logic [ROOT_W+3:0] trial;
		logic              ok;

		assign vx    = {1'b0, sq_rad_s[g], {SQ_PAD{1'b0}}};
		assign remx  = {sq_rem_s[g], vx[HI -: 2]};
		assign trial = remx - {2'b00, sq_root_s[g], 2'b01};
		assign ok    = remx >= {2'b00, sq_root_s[g], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				sq_vld_s[g+1] <= sq_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rad_s[g+1]  <= sq_rad_s[g];
				sq_rem_s[g+1]  <= ok ? trial[ROOT_W+1:0] : remx[ROOT_W+1:0];
				sq_root_s[g+1] <= {sq_root_s[g][ROOT_W-2:0], ok};
				sq_side_s[g+1] <= sq_side_s[g];
			end
		end
	end

	assign vld_out  = sq_vld_s[SQ_STEPS];
	assign root_out = sq_root_s[SQ_STEPS];
	assign side_out = sq_side_s[SQ_STEPS];

	`RMQ_ASSERT_IMPL(a_root_bound, sq_vld_s[SQ_STEPS], sq_root_s[SQ_STEPS] <= ROOT_MAX)

endmodule

// ----- sv/rmq_div.sv -----
// Three pipelined rounded dividers D*4096/P, saturation and output routing.
`include "rotation_matrix_to_quaternion_unit_assert.svh"
module rmq_div
	import rmq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vld_in,
	input  logic [ROOT_W-1:0]  root_in,
	input  side_t              side_in,
	output logic               vld_out,
	output quat_t              quat_out
);

	logic               dv_vld_s  [QUO_W+1];
	logic [ROOT_W-1:0]  dv_p_s    [QUO_W+1];
	prim_t              dv_prim_s [QUO_W+1];
	logic               dv_zero_s [QUO_W+1];
	logic [ROOT_W-1:0]  rem_s     [QUO_W+1][LANES];
	logic [QUO_W-1:0]   nlo_s     [QUO_W+1][LANES];
	logic [QUO_W-1:0]   quo_s     [QUO_W+1][LANES];
	logic               ov_s      [QUO_W+1][LANES];
	logic               neg_s     [QUO_W+1][LANES];

	logic               vld_s35;
	quat_t              quat_s35;
	el_t                lane_res  [LANES];

	// prep stage: magnitude, rounding bias, overflow check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (adv) begin
			dv_vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_p_s[0]    <= root_in;
			dv_prim_s[0] <= side_in.prim;
			dv_zero_s[0] <= root_in == '0;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic             neg;
		logic [D_W-1:0]   mag;
		logic [NUM_W-1:0] num;

		assign neg = side_in.d[l][D_W-1];
		assign mag = neg ? (~side_in.d[l] + 1'b1) : side_in.d[l];
		assign num = {1'b0, mag, {SQ_PAD{1'b0}}} + NUM_W'(root_in[ROOT_W-1:1]);

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[0][l] <= ROOT_W'(num[NUM_W-1:QUO_W]);
				nlo_s[0][l] <= num[QUO_W-1:0];
				quo_s[0][l] <= '0;
				ov_s[0][l]  <= ROOT_W'(num[NUM_W-1:QUO_W]) >= root_in;
				neg_s[0][l] <= neg;
			end
		end

		for (genvar g = 0; g < QUO_W; g++) begin : g_step
			logic [ROOT_W:0] remx;
			logic            ge;

			assign remx = {rem_s[g][l], nlo_s[g][l][QUO_W-1-g]};
			assign ge   = remx >= {1'b0, dv_p_s[g]};

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[g+1][l] <= ge ? ROOT_W'(remx - {1'b0, dv_p_s[g]})
						: remx[ROOT_W-1:0];
					nlo_s[g+1][l] <= nlo_s[g][l];
					quo_s[g+1][l] <= {quo_s[g][l][QUO_W-2:0], ge};
					ov_s[g+1][l]  <= ov_s[g][l];
					neg_s[g+1][l] <= neg_s[g][l];
				end
			end
		end

		// saturate the rounded quotient to a signed field
		always_comb begin
			if (dv_zero_s[QUO_W]) begin
				lane_res[l] = '0;
			end else if (neg_s[QUO_W][l]) begin
				if (ov_s[QUO_W][l] || quo_s[QUO_W][l] > QUO_W'(32768)) begin
					lane_res[l] = el_t'(16'h8000);
				end else begin
					lane_res[l] = el_t'(-quo_s[QUO_W][l]);
				end
			end else begin
				if (ov_s[QUO_W][l] || quo_s[QUO_W][l] > QUO_W'(32767)) begin
					lane_res[l] = el_t'(16'h7fff);
				end else begin
					lane_res[l] = el_t'(quo_s[QUO_W][l]);
				end
			end
		end
	end

	for (genvar g = 0; g < QUO_W; g++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[g+1] <= dv_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_p_s[g+1]    <= dv_p_s[g];
				dv_prim_s[g+1] <= dv_prim_s[g];
				dv_zero_s[g+1] <= dv_zero_s[g];
			end
		end
	end

	// output register: primary from the root, lanes routed by branch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s35 <= 1'b0;
		end else if (adv) begin
			vld_s35 <= dv_vld_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (dv_prim_s[QUO_W])
				PRIM_W: begin
					quat_s35 <= '{quat_w: el_t'(dv_p_s[QUO_W]), quat_x: lane_res[0],
						quat_y: lane_res[1], quat_z: lane_res[2]};
				end
				PRIM_X: begin
					quat_s35 <= '{quat_w: lane_res[0], quat_x: el_t'(dv_p_s[QUO_W]),
						quat_y: lane_res[1], quat_z: lane_res[2]};
				end
				PRIM_Y: begin
					quat_s35 <= '{quat_w: lane_res[0], quat_x: lane_res[2],
						quat_y: el_t'(dv_p_s[QUO_W]), quat_z: lane_res[1]};
				end
				PRIM_Z: begin
					quat_s35 <= '{quat_w: lane_res[0], quat_x: lane_res[1],
						quat_y: lane_res[2], quat_z: el_t'(dv_p_s[QUO_W])};
				end
				default: begin
					quat_s35 <= '0;
				end
			endcase
		end
	end

	assign vld_out  = vld_s35;
	assign quat_out = quat_s35;

	`RMQ_ASSERT_IMPL(a_rem_lane0, dv_vld_s[QUO_W] && !dv_zero_s[QUO_W] && !ov_s[QUO_W][0], rem_s[QUO_W][0] < dv_p_s[QUO_W])
	`RMQ_ASSERT_IMPL(a_rem_lane1, dv_vld_s[QUO_W] && !dv_zero_s[QUO_W] && !ov_s[QUO_W][1], rem_s[QUO_W][1] < dv_p_s[QUO_W])
	`RMQ_ASSERT_HOLDS(a_zero_ov, !dv_vld_s[QUO_W] || !dv_zero_s[QUO_W] || ov_s[QUO_W][2])

endmodule

// ----- sv/rotation_matrix_to_quaternion_unit.sv -----
// Top level: rotation matrix (Q1.14) to quaternion, Shepperd's method, pipelined.
//
//   channel   handshake                payload  direction
//   mat       mat_valid / mat_ready    mat_t    in
//   quat      quat_valid / quat_ready  quat_t   out
//
// One transaction per cycle sustained while quat_ready keeps the output moving; stages from accept to quat_valid:
//   1 branch/radicand stage, 15 square-root stages (one root bit each),
//   1 divider prep stage, 17 divider stages (one quotient bit each), 1 output register.
// The root and the three divides set the depth; each stage is one ~19-bit add/compare.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled quat transaction freezes the whole pipeline (mat_ready low) without
// losing or duplicating anything; empty stages keep flowing otherwise.
module rotation_matrix_to_quaternion_unit
	import rmq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   mat_valid,
	output logic   mat_ready,
	input  mat_t   mat,
	output logic   quat_valid,
	input  logic   quat_ready,
	output quat_t  quat
);

	logic              adv;          // global advance for every stage
	logic              vld_s1;
	logic [RAD_W-1:0]  rad_s1;
	side_t             side_s1;
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;

	// pipeline moves whenever the output slot is empty or being taken
	assign adv       = !quat_valid || quat_ready;
	assign mat_ready = adv;

	// trace test, largest-diagonal pick, radicand, off-diagonal terms
	rmq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_in  (mat_valid),
		.mat     (mat),
		.vld_s1  (vld_s1),
		.rad_s1  (rad_s1),
		.side_s1 (side_s1)
	);

	// P = floor(sqrt(R*4096)), the primary component
	rmq_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (vld_s1),
		.rad_in   (rad_s1),
		.side_in  (side_s1),
		.vld_out  (sq_vld),
		.root_out (sq_root),
		.side_out (sq_side)
	);

	// D*4096/P rounded half away from zero, saturated, then routed to w/x/y/z
	rmq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (sq_vld),
		.root_in  (sq_root),
		.side_in  (sq_side),
		.vld_out  (quat_valid),
		.quat_out (quat)
	);

endmodule

// ----- tb/sv/rmq_checker.sv -----
// Checker for the rotation-matrix-to-quaternion unit: predicts quaternions and compares them.
`timescale 1ns / 100ps
module rmq_checker
	import rmq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   mat_valid,
	input  logic   mat_ready,
	input  mat_t   mat,
	input  logic   quat_valid,
	input  logic   quat_ready,
	input  quat_t  quat,
	output int     errors,
	output int     pending
);

	quat_t quat_expected[$];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic el_t clip16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return el_t'(v);
	endfunction

	// d / (4p) in Q14, rounded half away from zero, saturated
	function automatic el_t ratio(longint d, longint unsigned p);
		longint unsigned mag;
		longint unsigned q;
		if (p == 0)
			return '0;
		mag = (d < 0) ? longint'(-d) : longint'(d);
		q = (mag * 4096 + (p >> 1)) / p;
		if (q > 65536)
			q = 65536;
		return clip16((d < 0) ? -longint'(q) : longint'(q));
	endfunction

	function automatic quat_t quat_from_matrix(mat_t m);
		longint a[3][3];
		longint tr;
		longint rad;
		longint unsigned p;
		el_t q[4];
		int i;
		int j;
		int k;
		quat_t res;
		a[0][0] = m.m00; a[0][1] = m.m01; a[0][2] = m.m02;
		a[1][0] = m.m10; a[1][1] = m.m11; a[1][2] = m.m12;
		a[2][0] = m.m20; a[2][1] = m.m21; a[2][2] = m.m22;
		tr = a[0][0] + a[1][1] + a[2][2];
		if (tr > 0) begin
			p = int_sqrt(longint'(tr + 16384) * 4096);
			q[3] = clip16(p);
			q[0] = ratio(a[1][2] - a[2][1], p);
			q[1] = ratio(a[2][0] - a[0][2], p);
			q[2] = ratio(a[0][1] - a[1][0], p);
		end else begin
			// largest diagonal, ties to the lower index
			i = 0;
			if (a[1][1] > a[0][0])
				i = 1;
			if (a[2][2] > a[i][i])
				i = 2;
			j = (i == 2) ? 0 : i + 1;
			k = (j == 2) ? 0 : j + 1;
			rad = a[i][i] - (a[j][j] + a[k][k]) + 16384;
			if (rad < 0)
				rad = 0;
			p = int_sqrt(rad * 4096);
			q[i] = clip16(p);
			q[3] = ratio(a[j][k] - a[k][j], p);
			q[j] = ratio(a[i][j] + a[j][i], p);
			q[k] = ratio(a[i][k] + a[k][i], p);
		end
		res.quat_w = q[3];
		res.quat_x = q[0];
		res.quat_y = q[1];
		res.quat_z = q[2];
		return res;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		quat_t exp_q;
		if (arst_n) begin
			if (mat_valid && mat_ready)
				quat_expected.push_back(quat_from_matrix(mat));
			if (quat_valid && quat_ready) begin
				if (quat_expected.size() == 0) begin
					$display("%t unexpected quat transaction: actual %h", $time, quat);
					errors <= errors + 1;
				end else begin
					exp_q = quat_expected.pop_front();
					if (quat.quat_w !== exp_q.quat_w || quat.quat_x !== exp_q.quat_x ||
						quat.quat_y !== exp_q.quat_y || quat.quat_z !== exp_q.quat_z) begin
						$display("%t quat mismatch: expected w=%0d x=%0d y=%0d z=%0d actual w=%0d x=%0d y=%0d z=%0d",
							$time, exp_q.quat_w, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z,
							quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
						errors <= errors + 1;
					end
				end
			end
			pending <= quat_expected.size();
		end
	end

endmodule

// ----- tb/sv/tb_rotation_matrix_to_quaternion_unit.sv -----
// Testbench top for the rotation-matrix-to-quaternion unit: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_rotation_matrix_to_quaternion_unit;
	import rmq_pkg::*;

	localparam int LATENCY   = 35;
	localparam int CYCLE_CAP = 400000;
	localparam int N_RANDOM  = 380;

	logic   clk;
	logic   arst_n;
	logic   mat_valid;
	logic   mat_ready;
	mat_t   mat;
	logic   quat_valid;
	logic   quat_ready;
	quat_t  quat;
	int     errors;
	int     pending;

	// idle odds out of 100 for sender and receiver
	int     send_idle_pct;
	int     recv_idle_pct;
	// receiver hold-off, in cycles, counted by the receiver process
	int     hold_cycles;
	int     cycle_count;

	rotation_matrix_to_quaternion_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.mat_valid  (mat_valid),
		.mat_ready  (mat_ready),
		.mat        (mat),
		.quat_valid (quat_valid),
		.quat_ready (quat_ready),
		.quat       (quat)
	);

	rmq_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.mat_valid  (mat_valid),
		.mat_ready  (mat_ready),
		.mat        (mat),
		.quat_valid (quat_valid),
		.quat_ready (quat_ready),
		.quat       (quat),
		.errors     (errors),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("[rotation_matrix_to_quaternion_unit] ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			quat_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			quat_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			quat_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Values that hit sign bits, ones and the range ends often.
	function automatic el_t pick_el();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sd16384;
			3: return -16'sd16384;
			4: return '0;
			5: return el_t'($urandom_range(32767) - 16384);
			default: return el_t'($urandom);
		endcase
	endfunction

	// A plausible rotation-like matrix: strong diagonal, small off-diagonals.
	function automatic mat_t pick_rotation_like();
		mat_t m;
		m = '{default: '0};
		m.m00 = el_t'($urandom_range(32767) - 16384);
		m.m11 = el_t'($urandom_range(32767) - 16384);
		m.m22 = el_t'($urandom_range(32767) - 16384);
		m.m01 = el_t'($urandom_range(16383) - 8192);
		m.m02 = el_t'($urandom_range(16383) - 8192);
		m.m10 = el_t'($urandom_range(16383) - 8192);
		m.m12 = el_t'($urandom_range(16383) - 8192);
		m.m20 = el_t'($urandom_range(16383) - 8192);
		m.m21 = el_t'($urandom_range(16383) - 8192);
		return m;
	endfunction

	// Offer one matrix at the falling edge and hold it until accepted.
	// Valid stays high afterwards; the caller or the next idle drops it.
	task automatic send_matrix(mat_t m);
		while ($urandom_range(99) < send_idle_pct) begin
			mat_valid <= 1'b0;
			@(negedge clk);
		end
		mat_valid <= 1'b1;
		mat <= m;
		@(posedge clk);
		while (!mat_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic mat_t diag_matrix(el_t d0, el_t d1, el_t d2);
		mat_t m;
		m = '{default: '0};
		m.m00 = d0;
		m.m11 = d1;
		m.m22 = d2;
		return m;
	endfunction

	initial begin
		mat_t m;
		arst_n = 1'b0;
		mat_valid = 1'b0;
		mat = '0;
		quat_ready = 1'b0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: identity, trace branch, zero trace, diagonal ties, saturation, field extremes.
		send_matrix(diag_matrix(16'sd16384, 16'sd16384, 16'sd16384));
		send_matrix(diag_matrix(16'sd16384, -16'sd16384, -16'sd16384));
		send_matrix(diag_matrix(-16'sd16384, 16'sd16384, -16'sd16384));
		send_matrix(diag_matrix(-16'sd16384, -16'sd16384, 16'sd16384));
		send_matrix(diag_matrix(16'sd100, -16'sd50, -16'sd50));
		send_matrix(diag_matrix('0, '0, '0));
		send_matrix(diag_matrix(16'sd5, 16'sd5, 16'sd5));
		send_matrix(diag_matrix(-16'sd5, -16'sd5, -16'sd5));
		send_matrix(diag_matrix(-16'sd16384, -16'sd16384, -16'sd16384));
		send_matrix(diag_matrix(-16'sd8192, 16'sd8192, 16'sd8192));
		send_matrix(diag_matrix(16'sh8000, 16'sh7fff, 16'sh7fff));
		send_matrix(diag_matrix(16'sh8000, 16'sh8000, 16'sh8000));
		send_matrix(diag_matrix(16'sh7fff, 16'sh7fff, 16'sh7fff));
		m = '{default: 16'sh7fff};
		send_matrix(m);
		m = '{default: 16'sh8000};
		send_matrix(m);
		m = '{default: 16'sh8000};
		m.m00 = 16'sh7fff;
		send_matrix(m);
		m = diag_matrix(16'sd1, 16'sd0, 16'sd0);
		m.m12 = 16'sh7fff; m.m21 = 16'sh8000; m.m01 = 16'sh7fff; m.m10 = 16'sh8000;
		send_matrix(m);
		m = diag_matrix(-16'sd16384, -16'sd16384, '0);
		m.m01 = 16'sh7fff; m.m10 = 16'sh7fff; m.m02 = 16'sh8000; m.m20 = 16'sh8000;
		send_matrix(m);
		// 90 degrees about z
		m = diag_matrix('0, '0, 16'sd16384);
		m.m01 = -16'sd16384; m.m10 = 16'sd16384;
		send_matrix(m);

		// Let everything drain before the random part.
		mat_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);

		// Long receiver hold-off while the sender keeps offering: fills the pipe.
		hold_cycles = 3 * LATENCY;
		repeat (50)
			send_matrix(pick_rotation_like());
		mat_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 0) begin
				send_idle_pct = 30;
				recv_idle_pct = 56;
			end else if (n == N_RANDOM / 3) begin
				send_idle_pct = 56;
				recv_idle_pct = 30;
			end else if (n == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if ($urandom_range(99) < 70) begin
				send_matrix(pick_rotation_like());
			end else begin
				m.m00 = pick_el(); m.m01 = pick_el(); m.m02 = pick_el();
				m.m10 = pick_el(); m.m11 = pick_el(); m.m12 = pick_el();
				m.m20 = pick_el(); m.m21 = pick_el(); m.m22 = pick_el();
				send_matrix(m);
			end
		end

		mat_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);

		if (errors == 0)
			$display("[rotation_matrix_to_quaternion_unit] OK");
		else
			$display("[rotation_matrix_to_quaternion_unit] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion_unit.sv
tb/sv/rmq_checker.sv
tb/sv/tb_rotation_matrix_to_quaternion_unit.sv
